@@ hw/rtl/ludec_pkg.sv @@
// Shared types and constants for the lenient UTF-8 decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ludec_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Byte classification masks and patterns
  localparam logic [7:0] MASK_1B = 8'h80;
  localparam logic [7:0] MASK_2B = 8'hE0;
  localparam logic [7:0] PAT_2B  = 8'hC0;
  localparam logic [7:0] MASK_3B = 8'hF0;
  localparam logic [7:0] PAT_3B  = 8'hE0;
  localparam logic [7:0] MASK_4B = 8'hF8;
  localparam logic [7:0] PAT_4B  = 8'hF0;
  localparam logic [7:0] MASK_CT = 8'hC0;
  localparam logic [7:0] PAT_CT  = 8'h80;
  localparam logic [7:0] PAY_2B  = 8'h1F;
  localparam logic [7:0] PAY_3B  = 8'h0F;
  localparam logic [7:0] PAY_4B  = 8'h07;
  localparam logic [7:0] PAY_CT  = 8'h3F;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]                        last_idx;  // number of results minus one
    logic                              eos;
    logic [MAX_RESULTS-1:0]            raw;
    logic [MAX_RESULTS-1:0][CP_W-1:0]  cp;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/ludec_front.sv @@
// Front end of the lenient UTF-8 decoder: accepts bytes, tracks the pending
// sequence and turns each byte into a burst of results. Depends on ludec_pkg.
module ludec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eos_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output ludec_pkg::burst_t   burst_o
);
  import ludec_pkg::*;

  logic [7:0]      leader_q, leader_d;
  logic [CP_W-1:0] accum_q, accum_d;
  logic [1:0]      needed_q, needed_d;
  logic [1:0]      seen_q, seen_d;
  logic [7:0]      cbuf_q [2];
  logic            cbuf_we;
  logic            accept;
  logic [2:0]      n;
  logic [CP_W-1:0] accum_ext;
  logic            is_cont;
  burst_t          burst;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_cont    = (in_byte_i & MASK_CT) == PAT_CT;
  assign accum_ext  = {accum_q[CP_W-7:0], in_byte_i[5:0] & PAY_CT[5:0]};

  always_comb begin
    leader_d = leader_q;
    accum_d  = accum_q;
    needed_d = needed_q;
    seen_d   = seen_q;
    cbuf_we  = 1'b0;
    n        = 3'd0;
    burst    = '0;
    burst.eos = in_eos_i;

    if ((needed_q != 2'd0) && is_cont) begin
      if (({1'b0, seen_q} + 3'd1) >= {1'b0, needed_q}) begin
        burst.cp[n[1:0]]  = accum_ext;
        burst.raw[n[1:0]] = 1'b0;
        n = n + 3'd1;
        leader_d = '0;
        accum_d  = '0;
        needed_d = '0;
        seen_d   = '0;
      end else begin
        cbuf_we = 1'b1;
        accum_d = accum_ext;
        seen_d  = seen_q + 2'd1;
      end
    end else begin
      // Flush the broken sequence raw, then treat the byte as a leader
      if (needed_q != 2'd0) begin
        burst.cp[n[1:0]]  = {13'd0, leader_q};
        burst.raw[n[1:0]] = 1'b1;
        n = n + 3'd1;
        if (seen_q > 2'd0) begin
          burst.cp[n[1:0]]  = {13'd0, cbuf_q[0]};
          burst.raw[n[1:0]] = 1'b1;
          n = n + 3'd1;
        end
        if (seen_q > 2'd1) begin
          burst.cp[n[1:0]]  = {13'd0, cbuf_q[1]};
          burst.raw[n[1:0]] = 1'b1;
          n = n + 3'd1;
        end
        leader_d = '0;
        accum_d  = '0;
        needed_d = '0;
        seen_d   = '0;
      end
      if ((in_byte_i & MASK_1B) == 8'h00) begin
        burst.cp[n[1:0]]  = {13'd0, in_byte_i};
        burst.raw[n[1:0]] = 1'b0;
        n = n + 3'd1;
      end else if ((in_byte_i & MASK_2B) == PAT_2B) begin
        leader_d = in_byte_i;
        accum_d  = {13'd0, in_byte_i & PAY_2B};
        needed_d = 2'd1;
        seen_d   = '0;
      end else if ((in_byte_i & MASK_3B) == PAT_3B) begin
        leader_d = in_byte_i;
        accum_d  = {13'd0, in_byte_i & PAY_3B};
        needed_d = 2'd2;
        seen_d   = '0;
      end else if ((in_byte_i & MASK_4B) == PAT_4B) begin
        leader_d = in_byte_i;
        accum_d  = {13'd0, in_byte_i & PAY_4B};
        needed_d = 2'd3;
        seen_d   = '0;
      end else begin
        burst.cp[n[1:0]]  = {13'd0, in_byte_i};
        burst.raw[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
    end

    // End of stream: drop whatever is still pending as raw bytes
    if (in_eos_i && (needed_d != 2'd0)) begin
      burst.cp[n[1:0]]  = {13'd0, leader_d};
      burst.raw[n[1:0]] = 1'b1;
      n = n + 3'd1;
      if (seen_d > 2'd0) begin
        burst.cp[n[1:0]]  = {13'd0, cbuf_q[0]};
        burst.raw[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
      if (seen_d > 2'd1) begin
        burst.cp[n[1:0]]  = {13'd0, (cbuf_we ? in_byte_i : cbuf_q[1])};
        burst.raw[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
      leader_d = '0;
      accum_d  = '0;
      needed_d = '0;
      seen_d   = '0;
    end

    burst.last_idx = n[1:0] - 2'd1;
  end

  // Corner: the eos flush may read the continuation buffered in this very
  // cycle; entry 0 is only ever written by the second byte, handle it too.
  always_comb begin
    burst_o = burst;
    if (in_eos_i && cbuf_we && (seen_q == 2'd0)) begin
      burst_o.cp[1] = {13'd0, in_byte_i};
    end
  end

  assign push_o = accept && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_q <= '0;
      accum_q  <= '0;
      needed_q <= '0;
      seen_q   <= '0;
    end else if (accept) begin
      leader_q <= leader_d;
      accum_q  <= accum_d;
      needed_q <= needed_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cbuf_we) begin
      cbuf_q[seen_q[0]] <= in_byte_i;
    end
  end

endmodule

@@ hw/rtl/ludec_queue.sv @@
// Short burst queue between the decoder front and back ends.
// Depends on ludec_pkg for the burst record and status types.
module ludec_queue #(
  parameter int unsigned QueueDepth = ludec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ludec_pkg::burst_t     push_data_i,
  input  logic                  pop_i,
  output ludec_pkg::burst_t     head_o,
  output ludec_pkg::q_status_t  status_o
);
  import ludec_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  burst_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

endmodule

@@ hw/rtl/ludec_back.sv @@
// Back end of the lenient UTF-8 decoder (uses ludec_pkg): walks each queued
// burst into the output register, one result per cycle unless stalled.
module ludec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ludec_pkg::burst_t     head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [ludec_pkg::CP_W-1:0] out_cp_o,
  output logic                  out_raw_o,
  output logic                  out_run_last_o,
  output logic                  out_stream_end_o
);
  import ludec_pkg::*;

  logic [1:0]      idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [CP_W-1:0] cp_q;
  logic            raw_q, run_last_q, stream_end_q;
  logic            load, last;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign last  = (idx_q == head_i.last_idx);
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q         <= head_i.cp[idx_q];
      raw_q        <= head_i.raw[idx_q];
      run_last_q   <= last;
      stream_end_q <= last && head_i.eos;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_cp_o         = cp_q;
  assign out_raw_o        = raw_q;
  assign out_run_last_o   = run_last_q;
  assign out_stream_end_o = stream_end_q;

endmodule

@@ hw/rtl/lenient_utf8_decoder_unit.sv @@
// Lenient UTF-8 decoder, top level: front end, burst queue and back end.
// Depends on ludec_pkg, ludec_front, ludec_queue and ludec_back.
//
// Takes one UTF-8 byte per transaction on the slave side and emits decoded
// code points on the master side. Overlong forms and surrogates are accepted
// as decoded. Stray continuation bytes and 5/6-byte leaders pass through raw;
// a sequence broken by a non-continuation byte or by tlast is flushed as its
// raw bytes, one result each, and the breaking byte is then decoded afresh.
// Rate: a byte is accepted every cycle as long as the burst queue is not
// full. Each byte yields 0 to 4 results, and the back end issues one result
// per cycle while the master side is ready, so sustained throughput is one
// byte per cycle for well-formed text and drops while bytes cause more than
// one result each. An accepted byte's burst is written into the queue at
// the accepting edge and moves from there into the output register. No
// clearing pass follows reset.
module lenient_utf8_decoder_unit #(
  parameter int unsigned QueueDepth = ludec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [0] passed_raw, [1] run_last
  output logic        m_axis_tlast    // stream_end
);
  import ludec_pkg::*;

  logic                push;
  logic                pop;
  burst_t              push_burst;
  burst_t              head;
  q_status_t           q_stat;
  logic [CP_W-1:0]     out_cp;

  // Classify bytes and build one burst of results per byte
  ludec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_eos_i   (s_axis_tlast),
    .q_full_i   (q_stat.full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .burst_o    (push_burst)
  );

  // Hold bursts so the two sides stall independently
  ludec_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_burst),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_stat)
  );

  // Serialize each burst onto the master side
  ludec_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_valid_i     (!q_stat.empty),
    .pop_o            (pop),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_cp_o         (out_cp),
    .out_raw_o        (m_axis_tuser[0]),
    .out_run_last_o   (m_axis_tuser[1]),
    .out_stream_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_cp};

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("burst queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("burst queue underflow");

  // The end of the stream is always the last result of its byte
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
    else $error("stream end without run last");

  // An accepted end-of-stream byte always produces a result
  a_eos_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> push)
    else $error("end of stream byte produced no burst");

endmodule
